// ===== hdl/drrs_pkg.sv =====
// shared types, constants and helpers of the two-processor round-robin scheduler
// no dependencies; used by every module of the block
package drrs_pkg;

  localparam int JOB_W   = 4;
  localparam int NJOB    = 16;
  localparam int WORK_W  = 16;
  localparam int SLICE_W = 8;
  localparam int TIME_W  = 32;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;

  // command codes carried on the input tuser
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // result kinds carried on the output tuser
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // configuration register indexes
  localparam logic REG_SLICE_ONE = 1'b0;
  localparam logic REG_SLICE_TWO = 1'b1;

  // one ready queue entry: job and the work it still needs
  typedef struct packed {
    logic [JOB_W-1:0]  job;
    logic [WORK_W-1:0] rem;
  } entry_t;

  // queue update for one cycle: entries pushed in order, then popped from the head
  typedef struct packed {
    logic [1:0] push_cnt;
    logic [1:0] pop_cnt;
    entry_t     e0;
    entry_t     e1;
  } q_op_t;

  typedef struct packed {
    logic              kind;
    logic              error;
    logic [TIME_W-1:0] now;
    logic              busy_one;
    logic [JOB_W-1:0]  job_one;
    logic              busy_two;
    logic [JOB_W-1:0]  job_two;
    logic              finish_one;
    logic              finish_two;
    logic              first_one;
    logic              first_two;
  } res_t;

  // a zero slice counts as one tick
  function automatic logic [SLICE_W-1:0] reload(input logic [SLICE_W-1:0] v);
    reload = (v == '0) ? SLICE_W'(1) : v;
  endfunction

endpackage

// ===== hdl/drrs_queue.sv =====
// ready queue of the scheduler: shift queue, head always at entry zero
// depends on drrs_pkg
module drrs_queue #(
  parameter int QD = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  drrs_pkg::q_op_t         op,
  output drrs_pkg::entry_t        head0,
  output drrs_pkg::entry_t        head1,
  output logic [$clog2(QD+1)-1:0] count
);

  localparam int CW = $clog2(QD + 1);
  localparam int IW = $clog2(QD);

  drrs_pkg::entry_t q [QD];
  drrs_pkg::entry_t q_next [QD];

  assign head0 = q[0];
  assign head1 = q[1];

  // each slot takes the element pop_cnt places further along the list of
  // stored entries followed by the pushed ones
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      if ((i + int'(op.pop_cnt)) < int'(count)) begin
        q_next[i] = q[IW'(i + int'(op.pop_cnt))];
      end else if ((i + int'(op.pop_cnt)) == int'(count)) begin
        q_next[i] = op.e0;
      end else begin
        q_next[i] = op.e1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q[i] <= q_next[i];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CW'(op.push_cnt) - CW'(op.pop_cnt);
    end
  end

endmodule

// ===== hdl/drrs_core.sv =====
// scheduler state and the single-pass step for one arrival or tick
// depends on drrs_pkg and drrs_queue
module drrs_core #(
  parameter int MAX_JOBS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          cmd,
  input  logic [drrs_pkg::JOB_W-1:0]    job,
  input  logic [drrs_pkg::WORK_W-1:0]   work,
  input  logic [drrs_pkg::SLICE_W-1:0]  slice_one,
  input  logic [drrs_pkg::SLICE_W-1:0]  slice_two,
  output drrs_pkg::res_t                res
);

  localparam int QD = (MAX_JOBS < drrs_pkg::NJOB) ? MAX_JOBS : drrs_pkg::NJOB;
  localparam int CW = $clog2(QD + 1);
  localparam int TW = CW + 1;

  drrs_pkg::q_op_t  op;
  drrs_pkg::entry_t head0;
  drrs_pkg::entry_t head1;
  logic [CW-1:0]    cnt;

  // per-processor state
  logic                         rv [2];
  logic [drrs_pkg::JOB_W-1:0]   rj [2];
  logic [drrs_pkg::WORK_W-1:0]  rr [2];
  logic [drrs_pkg::SLICE_W-1:0] sl [2];
  logic                         ex [2];
  logic                         rv_next [2];
  logic [drrs_pkg::JOB_W-1:0]   rj_next [2];
  logic [drrs_pkg::WORK_W-1:0]  rr_next [2];
  logic [drrs_pkg::SLICE_W-1:0] sl_next [2];
  logic                         ex_next [2];
  logic [drrs_pkg::SLICE_W-1:0] sl_cfg [2];

  logic [drrs_pkg::NJOB-1:0]    known;
  logic [drrs_pkg::NJOB-1:0]    known_next;
  logic [drrs_pkg::NJOB-1:0]    started;
  logic [drrs_pkg::NJOB-1:0]    started_next;
  logic [drrs_pkg::TIME_W-1:0]  time_now;
  logic [drrs_pkg::TIME_W-1:0]  time_next;

  logic                         arr_ok;
  logic [TW-1:0]                total;
  logic [1:0]                   npush;
  logic [1:0]                   npop;
  drrs_pkg::entry_t             take;
  drrs_pkg::entry_t             h0;
  drrs_pkg::entry_t             h1;
  drrs_pkg::entry_t             req;
  logic [drrs_pkg::WORK_W-1:0]  rem;
  logic                         ran [2];
  logic                         fin [2];
  logic                         first [2];

  assign sl_cfg[0] = slice_one;
  assign sl_cfg[1] = slice_two;

  drrs_queue #(
    .QD(QD)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .head0 (head0),
    .head1 (head1),
    .count (cnt)
  );

  // arrival check: new job index, in range, room in the queue
  assign arr_ok = !known[job] && (int'(job) < MAX_JOBS) && (int'(cnt) < QD);

  // one step: arrival, or requeue, dispatch, run and retire
  always_comb begin
    op           = '0;
    res          = '0;
    known_next   = known;
    started_next = started;
    time_next    = time_now;
    npush        = '0;
    npop         = '0;
    total        = '0;
    h0           = head0;
    h1           = head1;
    take         = head0;
    req          = '0;
    rem          = '0;
    for (int p = 0; p < 2; p++) begin
      rv_next[p] = rv[p];
      rj_next[p] = rj[p];
      rr_next[p] = rr[p];
      sl_next[p] = sl[p];
      ex_next[p] = ex[p];
      ran[p]     = 1'b0;
      fin[p]     = 1'b0;
      first[p]   = 1'b0;
    end

    if (step && (cmd == drrs_pkg::CMD_ARRIVAL)) begin
      op.push_cnt = {1'b0, arr_ok};
      op.e0.job   = job;
      op.e0.rem   = (work == '0) ? drrs_pkg::WORK_W'(1) : work;
      if (arr_ok) begin
        known_next[job] = 1'b1;
      end
      res.kind  = drrs_pkg::KIND_ACK;
      res.error = !arr_ok;
      res.now   = time_now;
    end else if (step) begin
      // requeue jobs whose slice ran out last tick, processor one first
      for (int p = 0; p < 2; p++) begin
        if (ex[p]) begin
          if (rv[p]) begin
            req.job = rj[p];
            req.rem = rr[p];
            if (npush == 2'd0) begin
              op.e0 = req;
            end else begin
              op.e1 = req;
            end
            npush = npush + 2'd1;
          end
          rv_next[p] = 1'b0;
          ex_next[p] = 1'b0;
          sl_next[p] = drrs_pkg::reload(sl_cfg[p]);
        end
      end

      // fill idle processors from the head of stored-then-pushed entries
      total = TW'(cnt) + TW'(npush);
      h0 = (cnt >= CW'(1)) ? head0 : op.e0;
      h1 = (cnt >= CW'(2)) ? head1 : ((cnt == CW'(1)) ? op.e0 : op.e1);
      for (int p = 0; p < 2; p++) begin
        if (!rv_next[p] && (total > TW'(npop))) begin
          take = (npop == 2'd0) ? h0 : h1;
          rv_next[p] = 1'b1;
          rj_next[p] = take.job;
          rr_next[p] = take.rem;
          if (!started_next[take.job]) begin
            started_next[take.job] = 1'b1;
            first[p] = 1'b1;
          end
          npop = npop + 2'd1;
        end
      end
      op.push_cnt = npush;
      op.pop_cnt  = npop;

      time_next = time_now + drrs_pkg::TIME_W'(1);

      // run one unit, then retire or mark for requeue
      for (int p = 0; p < 2; p++) begin
        if (rv_next[p]) begin
          ran[p] = 1'b1;
          rem = (rr_next[p] != '0) ? (rr_next[p] - drrs_pkg::WORK_W'(1)) : '0;
          rr_next[p] = rem;
          if (sl_next[p] != '0) begin
            sl_next[p] = sl_next[p] - drrs_pkg::SLICE_W'(1);
          end
          if (rem == '0) begin
            fin[p]     = 1'b1;
            rv_next[p] = 1'b0;
            sl_next[p] = drrs_pkg::reload(sl_cfg[p]);
          end else if (sl[p] <= drrs_pkg::SLICE_W'(1) || ex[p]) begin
            ex_next[p] = (ex[p] ? (drrs_pkg::reload(sl_cfg[p]) <= drrs_pkg::SLICE_W'(1))
                                : 1'b1);
          end
        end
      end

      res.kind       = drrs_pkg::KIND_TICK;
      res.error      = 1'b0;
      res.now        = time_next;
      res.busy_one   = ran[0];
      res.job_one    = ran[0] ? rj_next[0] : '0;
      res.busy_two   = ran[1];
      res.job_two    = ran[1] ? rj_next[1] : '0;
      res.finish_one = fin[0];
      res.finish_two = fin[1];
      res.first_one  = first[0];
      res.first_two  = first[1];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      known    <= '0;
      started  <= '0;
      time_now <= '0;
      for (int p = 0; p < 2; p++) begin
        rv[p] <= 1'b0;
        rj[p] <= '0;
        sl[p] <= drrs_pkg::SLICE_RESET;
        ex[p] <= 1'b0;
      end
    end else if (step) begin
      known    <= known_next;
      started  <= started_next;
      time_now <= time_next;
      for (int p = 0; p < 2; p++) begin
        rv[p] <= rv_next[p];
        rj[p] <= rj_next[p];
        sl[p] <= sl_next[p];
        ex[p] <= ex_next[p];
      end
    end
  end

  // remaining work of the running jobs
  always_ff @(posedge clk) begin
    if (step) begin
      for (int p = 0; p < 2; p++) begin
        rr[p] <= rr_next[p];
      end
    end
  end

  // the queue never holds more entries than its depth
  assert property (@(posedge clk) disable iff (rst) int'(cnt) <= QD)
    else $error("ready queue count above depth");

  // a job marked for requeue is still on its processor
  assert property (@(posedge clk) disable iff (rst) (!ex[0] || rv[0]) && (!ex[1] || rv[1]))
    else $error("expiry marked on an idle processor");

  // one job never runs on both processors
  assert property (@(posedge clk) disable iff (rst) (rv[0] && rv[1]) |-> (rj[0] != rj[1]))
    else $error("same job on both processors");

  // slice counter only reaches zero together with an expiry mark
  assert property (@(posedge clk) disable iff (rst)
    (ex[0] || (sl[0] != '0)) && (ex[1] || (sl[1] != '0)))
    else $error("empty slice without expiry");

  // time moves by exactly one on each tick
  assert property (@(posedge clk) disable iff (rst)
    (step && (cmd == drrs_pkg::CMD_TICK)) |=> (time_now == $past(time_now) + 32'd1))
    else $error("time did not advance on tick");

endmodule

// ===== hdl/dual_processor_round_robin_scheduler_top.sv =====
// top level of the two-processor round-robin scheduler: stream ports,
// slice registers, input register and result register around drrs_core
// depends on drrs_pkg, drrs_core, drrs_queue
//
//  channel | direction | handshake          | contents
//  s_      | in        | s_tvalid/s_tready  | tuser cmd; tdata job, work
//  m_      | out       | m_tvalid/m_tready  | tuser kind; tdata result fields
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// one item per cycle sustained while m_tready stays high; each result passes through
// the input register, then the single-pass step into the result register
// synchronous reset: queue empty, processors idle, time zero, both slices 4
// a stalled result holds in the result register; one more item waits in the
// input register, after which s_tready drops until m_tready returns
module dual_processor_round_robin_scheduler_top #(
  parameter int MAX_JOBS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [drrs_pkg::IN_TDATA_W-1:0]     s_tdata,   // job[3:0], work[19:4], zero
  input  logic                                s_tuser,   // cmd
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [drrs_pkg::OUT_TDATA_W-1:0]    m_tdata,   // error, now[32], busy_one, job_one,
                                                         // busy_two, job_two, finish_one,
                                                         // finish_two, first_one, first_two, zero
  output logic                                m_tuser,   // kind
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [drrs_pkg::SLICE_W-1:0]        cfg_data
);

  logic                          in_valid;
  logic                          in_cmd;
  logic [drrs_pkg::JOB_W-1:0]    in_job;
  logic [drrs_pkg::WORK_W-1:0]   in_work;
  logic                          advance;
  logic [drrs_pkg::SLICE_W-1:0]  slice_one;
  logic [drrs_pkg::SLICE_W-1:0]  slice_two;
  drrs_pkg::res_t                res;
  drrs_pkg::res_t                res_q;

  assign cfg_ready = !rst;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !rst && (!in_valid || advance);

  // slice registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_one <= drrs_pkg::SLICE_RESET;
      slice_two <= drrs_pkg::SLICE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        drrs_pkg::REG_SLICE_ONE: slice_one <= cfg_data;
        drrs_pkg::REG_SLICE_TWO: slice_two <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_job  <= s_tdata[3:0];
      in_work <= s_tdata[19:4];
    end
  end

  drrs_core #(
    .MAX_JOBS(MAX_JOBS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .cmd       (in_cmd),
    .job       (in_job),
    .work      (in_work),
    .slice_one (slice_one),
    .slice_two (slice_two),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tuser = res_q.kind;
  assign m_tdata = {1'b0, res_q.first_two, res_q.first_one, res_q.finish_two,
                    res_q.finish_one, res_q.job_two, res_q.busy_two, res_q.job_one,
                    res_q.busy_one, res_q.now, res_q.error};

endmodule
